### design/dbdc_pkg.sv
// Shared types and constants for the day bucket distinct counter.
// Used by the front, the queue and the back of the block; no dependencies.
package dbdc_pkg;

    localparam int SECS_W      = 40;
    localparam int KEY_W       = 24;
    localparam int COUNT_W     = 32;
    localparam int LIMIT_W     = 7;
    localparam int QUEUE_DEPTH = 2;

    // The 86400 seconds of a day split as 2^DAY_SHIFT times the odd factor 675.
    // DAY_RECIP is floor(2^RECIP_SHIFT / 675).
    localparam int DAY_SHIFT   = 7;
    localparam int RECIP_SHIFT = 33;
    localparam logic [9:0]       DAY_ODD   = 10'd675;
    localparam logic [KEY_W-1:0] DAY_RECIP = 24'd12725829;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic KIND_WINDOW  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
    } queue_item_t;

endpackage

### design/day_bucket_distinct_counter.sv
// Top level of the day bucket distinct counter: front, queue and back.
// Depends on dbdc_pkg, dbdc_front, dbdc_queue and dbdc_back.
//
//  channel  | handshake             | fields
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | kind, acquired_seconds
//  result   | out_valid / out_ready | slot_index, day_key, day_count, is_new,
//           |                       | ignored, distinct_total
//  config   | cfg_we (no wait)      | cfg_wdata (table_limit)
//
// A window item passes the front's capture, reciprocal multiply, remainder
// correction and push steps; the back then scans the used entries in turn
// through the key memory's single read port and appends the day on a miss
// while the limit allows. The queue lets the front take items during a scan.
// Restart items, and window items once grouping stops, skip the scan.
// Reset needs no clearing pass: only entries below the used count are read.
// A result waiting in the output register stalls only the back's final step.
module day_bucket_distinct_counter #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dbdc_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [dbdc_pkg::SECS_W-1:0]   acquired_seconds,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              slot_index,
    output logic [dbdc_pkg::KEY_W-1:0]    day_key,
    output logic [dbdc_pkg::COUNT_W-1:0]  day_count,
    output logic                          is_new,
    output logic                          ignored,
    output logic [CNT_W-1:0]              distinct_total
);
    import dbdc_pkg::*;

    logic        push_valid, push_ready;
    queue_item_t push_item;
    logic        pop_valid, pop_ready;
    queue_item_t pop_item;

    dbdc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .acquired_seconds (acquired_seconds),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    dbdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dbdc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_item         (pop_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot_index     (slot_index),
        .day_key        (day_key),
        .day_count      (day_count),
        .is_new         (is_new),
        .ignored        (ignored),
        .distinct_total (distinct_total)
    );

endmodule

### design/dbdc_ram.sv
// Generic simple dual port RAM with one write port and one registered read port.
// No package dependencies.
module dbdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/dbdc_front.sv
// Front of the day bucket distinct counter: accepts items and turns the timestamp
// into a day key with a reciprocal multiplication. Depends on dbdc_pkg.
module dbdc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [dbdc_pkg::SECS_W-1:0]   acquired_seconds,
    output logic                          push_valid,
    input  logic                          push_ready,
    output dbdc_pkg::queue_item_t         push_item
);
    import dbdc_pkg::*;

    localparam int Y_W    = SECS_W - DAY_SHIFT;
    localparam int PROD_W = Y_W + KEY_W;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_FIX,
        F_PUSH
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [Y_W-1:0]    secs_reg, secs_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              kind_reg, kind_next;

    logic [PROD_W-1:0] prod;
    logic [Y_W-1:0]    key_times_odd;
    logic [Y_W-1:0]    rem_val;

    // The shifted time times the reciprocal lands at most one below the true
    // quotient, so a remainder of 675 or more means the estimate is one short.
    always_comb
    begin
        prod          = PROD_W'(secs_reg) * PROD_W'(DAY_RECIP);
        key_times_odd = Y_W'(key_reg) * Y_W'(DAY_ODD);
        rem_val       = secs_reg - key_times_odd;
    end

    always_comb
    begin
        state_next = state_reg;
        secs_next  = secs_reg;
        key_next   = key_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    if (kind == KIND_RESTART)
                    begin
                        key_next   = '0;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        secs_next  = acquired_seconds[SECS_W-1:DAY_SHIFT];
                        state_next = F_MUL;
                    end
                end
            end
            F_MUL:
            begin
                key_next   = prod[RECIP_SHIFT +: KEY_W];
                state_next = F_FIX;
            end
            F_FIX:
            begin
                if (rem_val >= Y_W'(DAY_ODD))
                begin
                    key_next = key_reg + KEY_W'(1);
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= secs_next;
        key_reg  <= key_next;
        kind_reg <= kind_next;
    end

    assign in_ready       = (state_reg == F_IDLE);
    assign push_valid     = (state_reg == F_PUSH);
    assign push_item.kind = kind_reg;
    assign push_item.key  = key_reg;

endmodule

### design/dbdc_queue.sv
// Short queue of classified items between the front and the back.
// Depends on dbdc_pkg for the item type and depth.
module dbdc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  dbdc_pkg::queue_item_t  push_item,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output dbdc_pkg::queue_item_t  pop_item
);
    import dbdc_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/dbdc_back.sv
// Back of the day bucket distinct counter: scans the key table, updates counts,
// appends new days and holds the result register. Depends on dbdc_pkg, dbdc_ram.
module dbdc_back #(
    parameter int TABLE_DEPTH = 64,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dbdc_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  dbdc_pkg::queue_item_t         q_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              slot_index,
    output logic [dbdc_pkg::KEY_W-1:0]    day_key,
    output logic [dbdc_pkg::COUNT_W-1:0]  day_count,
    output logic                          is_new,
    output logic                          ignored,
    output logic [CNT_W-1:0]              distinct_total
);
    import dbdc_pkg::*;

    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);

    typedef enum logic {
        B_IDLE,
        B_SCAN
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic               stopped_reg, stopped_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [KEY_W-1:0]   okey_reg, okey_next;
    logic [COUNT_W-1:0] ocount_reg, ocount_next;
    logic               new_reg, new_next;
    logic               ign_reg, ign_next;
    logic [CNT_W-1:0]   total_reg, total_next;

    logic [LIM_W-1:0]   eff_limit;
    logic [CNT_W-1:0]   used_inc;
    logic               out_free;
    logic               hit, scan_end, table_full;
    logic [KEY_W-1:0]   key_rdata;
    logic [COUNT_W-1:0] cnt_rdata, cnt_sat;

    logic               rd_en;
    logic               key_we, cnt_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] cnt_wdata;

    // Both stores are read at the same address so a matching key comes with its count.
    dbdc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    dbdc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (wr_addr),
        .wdata (cnt_wdata),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (cnt_rdata)
    );

    // A limit of zero acts as one, and a limit above the table acts as its depth.
    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = LIM_W'(1);
        end
        else if (LIM_W'(limit_reg) > DEPTH_L)
        begin
            eff_limit = DEPTH_L;
        end
        else
        begin
            eff_limit = LIM_W'(limit_reg);
        end
    end

    assign used_inc   = used_reg + CNT_W'(1);
    assign out_free   = !out_valid_reg || out_ready;
    assign hit        = (state_reg == B_SCAN) && cmp_valid_reg && (key_rdata == key_reg);
    assign scan_end   = (state_reg == B_SCAN) && !cmp_valid_reg && (issue_reg == used_reg);
    assign table_full = (LIM_W'(used_reg) >= eff_limit);
    assign cnt_sat    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        key_next       = key_reg;
        used_next      = used_reg;
        stopped_next   = stopped_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;

        out_valid_next = out_valid_reg && !out_ready;
        slot_next      = slot_reg;
        okey_next      = okey_reg;
        ocount_next    = ocount_reg;
        new_next       = new_reg;
        ign_next       = ign_reg;
        total_next     = total_reg;

        q_ready   = 1'b0;
        rd_en     = 1'b0;
        key_we    = 1'b0;
        cnt_we    = 1'b0;
        wr_addr   = used_reg[IDX_W-1:0];
        cnt_wdata = COUNT_W'(1);

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == KIND_RESTART)
                    begin
                        if (out_free)
                        begin
                            q_ready        = 1'b1;
                            used_next      = '0;
                            stopped_next   = 1'b0;
                            out_valid_next = 1'b1;
                            slot_next      = '0;
                            okey_next      = '0;
                            ocount_next    = '0;
                            new_next       = 1'b0;
                            ign_next       = 1'b1;
                            total_next     = '0;
                        end
                    end
                    else if (stopped_reg)
                    begin
                        if (out_free)
                        begin
                            q_ready        = 1'b1;
                            out_valid_next = 1'b1;
                            slot_next      = '0;
                            okey_next      = q_item.key;
                            ocount_next    = '0;
                            new_next       = 1'b0;
                            ign_next       = 1'b1;
                            total_next     = used_reg;
                        end
                    end
                    else
                    begin
                        q_ready        = 1'b1;
                        key_next       = q_item.key;
                        issue_next     = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = B_SCAN;
                    end
                end
            end
            B_SCAN:
            begin
                if (hit)
                begin
                    if (out_free)
                    begin
                        cnt_we         = 1'b1;
                        wr_addr        = cmp_idx_reg;
                        cnt_wdata      = cnt_sat;
                        out_valid_next = 1'b1;
                        slot_next      = cmp_idx_reg;
                        okey_next      = key_reg;
                        ocount_next    = cnt_sat;
                        new_next       = 1'b0;
                        ign_next       = 1'b0;
                        total_next     = used_reg;
                        state_next     = B_IDLE;
                    end
                end
                else if (scan_end)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        okey_next      = key_reg;
                        state_next     = B_IDLE;
                        if (table_full)
                        begin
                            stopped_next = 1'b1;
                            slot_next    = '0;
                            ocount_next  = '0;
                            new_next     = 1'b0;
                            ign_next     = 1'b1;
                            total_next   = used_reg;
                        end
                        else
                        begin
                            key_we       = 1'b1;
                            cnt_we       = 1'b1;
                            used_next    = used_inc;
                            stopped_next = (LIM_W'(used_inc) >= eff_limit);
                            slot_next    = used_reg[IDX_W-1:0];
                            ocount_next  = COUNT_W'(1);
                            new_next     = 1'b1;
                            ign_next     = 1'b0;
                            total_next   = used_inc;
                        end
                    end
                end
                else if (issue_reg < used_reg)
                begin
                    // Read the next entry while the previous one is compared.
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            limit_reg     <= LIMIT_RESET;
            used_reg      <= '0;
            stopped_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            used_reg      <= used_next;
            stopped_reg   <= stopped_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        okey_reg    <= okey_next;
        ocount_reg  <= ocount_next;
        new_reg     <= new_next;
        ign_reg     <= ign_next;
        total_reg   <= total_next;
    end

    assign out_valid      = out_valid_reg;
    assign slot_index     = slot_reg;
    assign day_key        = okey_reg;
    assign day_count      = ocount_reg;
    assign is_new         = new_reg;
    assign ignored        = ign_reg;
    assign distinct_total = total_reg;

endmodule

### tb/day_bucket_distinct_checker.sv
`timescale 1ns / 100ps
// Checker for the day bucket distinct counter: watches the input, result and config ports,
// predicts each result from its own copy of the day table, and counts mismatches.
// Depends on dbdc_pkg for field widths, kind codes and the limit reset value.
module day_bucket_distinct_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dbdc_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          kind,
    input  logic [dbdc_pkg::SECS_W-1:0]   acquired_seconds,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [IDX_W-1:0]              slot_index,
    input  logic [dbdc_pkg::KEY_W-1:0]    day_key,
    input  logic [dbdc_pkg::COUNT_W-1:0]  day_count,
    input  logic                          is_new,
    input  logic                          ignored,
    input  logic [CNT_W-1:0]              distinct_total,
    output int                            fail_count,
    output int                            expected_left
);
    import dbdc_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   slot;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic               created;
        logic               dropped;
        logic [CNT_W-1:0]   total;
    } bucket_result_t;

    bucket_result_t     expected_buckets[$];
    bucket_result_t     oldest;
    logic [KEY_W-1:0]   stored_keys[TABLE_DEPTH];
    logic [COUNT_W-1:0] day_counts[TABLE_DEPTH];
    int                 used_days   = 0;
    bit                 grouping_off = 1'b0;
    logic [LIMIT_W-1:0] limit_reg   = LIMIT_RESET;
    int                 errors      = 0;
    int                 waiting     = 0;

    assign fail_count    = errors;
    assign expected_left = waiting;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Updates the table copy for one input transfer and returns the result it causes.
    function automatic bucket_result_t group_by_day(input logic item_kind,
                                                    input logic [SECS_W-1:0] secs);
        bucket_result_t res;
        logic [63:0]    quotient;
        int             cap;
        int             hit;
        quotient    = 64'(secs) / 64'd86400;
        res.slot    = '0;
        res.key     = quotient[KEY_W-1:0];
        res.count   = '0;
        res.created = 1'b0;
        res.dropped = 1'b1;
        res.total   = CNT_W'(used_days);
        hit         = -1;
        if (item_kind == KIND_RESTART)
        begin
            used_days    = 0;
            grouping_off = 1'b0;
            res.key      = '0;
            res.total    = '0;
        end
        else if (!grouping_off)
        begin
            for (int i = 0; i < used_days; i++)
            begin
                if (hit < 0 && stored_keys[i] == res.key)
                    hit = i;
            end
            cap = (limit_reg == 0) ? 1 : ((limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg);
            if (hit >= 0)
            begin
                if (day_counts[hit] != '1)
                    day_counts[hit] = day_counts[hit] + 1'b1;
                res.slot    = IDX_W'(hit);
                res.count   = day_counts[hit];
                res.dropped = 1'b0;
            end
            else if (used_days >= cap)
            begin
                // A miss with the table already at its limit stops grouping.
                grouping_off = 1'b1;
            end
            else
            begin
                stored_keys[used_days] = res.key;
                day_counts[used_days]  = COUNT_W'(1);
                res.slot    = IDX_W'(used_days);
                res.count   = COUNT_W'(1);
                res.created = 1'b1;
                res.dropped = 1'b0;
                used_days++;
                res.total   = CNT_W'(used_days);
                if (used_days >= cap)
                    grouping_off = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_days    = 0;
            grouping_off = 1'b0;
            limit_reg    = LIMIT_RESET;
            expected_buckets.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_buckets.size() == 0)
                    report_mismatch("result transfer with nothing pending", 0, 0);
                else
                begin
                    oldest = expected_buckets.pop_front();
                    check_field("slot_index", slot_index, oldest.slot);
                    check_field("day_key", day_key, oldest.key);
                    check_field("day_count", day_count, oldest.count);
                    check_field("is_new", is_new, oldest.created);
                    check_field("ignored", ignored, oldest.dropped);
                    check_field("distinct_total", distinct_total, oldest.total);
                end
            end
            if (cfg_we)
                limit_reg = cfg_wdata;
            if (in_valid && in_ready)
                expected_buckets.push_back(group_by_day(kind, acquired_seconds));
        end
        waiting = expected_buckets.size();
    end

endmodule

### tb/day_bucket_distinct_counter_tb.sv
`timescale 1ns / 100ps
// Top of the day bucket distinct counter testbench: clock, reset, stimulus and verdict.
// Depends on dbdc_pkg, the block itself and day_bucket_distinct_checker.
module day_bucket_distinct_counter_tb;
    import dbdc_pkg::*;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 800;
    localparam logic [KEY_W-1:0]  MAX_KEY  = 24'd12725829;
    localparam logic [SECS_W-1:0] MAX_SECS = '1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [LIMIT_W-1:0]   cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [SECS_W-1:0]    acquired_seconds;
    logic                 out_valid;
    logic                 out_ready;
    logic [IDX_W-1:0]     slot_index;
    logic [KEY_W-1:0]     day_key;
    logic [COUNT_W-1:0]   day_count;
    logic                 is_new;
    logic                 ignored;
    logic [CNT_W-1:0]     distinct_total;
    int                   fail_count;
    int                   expected_left;
    int                   cycle_count = 0;
    logic                 calm;
    logic                 hold_req;

    always #5 clk = ~clk;

    day_bucket_distinct_counter #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .acquired_seconds(acquired_seconds), .out_valid(out_valid), .out_ready(out_ready),
        .slot_index(slot_index), .day_key(day_key), .day_count(day_count),
        .is_new(is_new), .ignored(ignored), .distinct_total(distinct_total)
    );

    day_bucket_distinct_checker #(.TABLE_DEPTH(DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .acquired_seconds(acquired_seconds), .out_valid(out_valid), .out_ready(out_ready),
        .slot_index(slot_index), .day_key(day_key), .day_count(day_count),
        .is_new(is_new), .ignored(ignored), .distinct_total(distinct_total),
        .fail_count(fail_count), .expected_left(expected_left)
    );

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while calm.
    initial
    begin : receiver
        int hold_left;
        bit hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 24);
        end
    end

    function automatic logic [SECS_W-1:0] random_seconds();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[SECS_W-1:0];
    endfunction

    // Starts and ends just after a falling edge; offers one item until its transfer.
    task automatic send_item(input logic item_kind, input logic [SECS_W-1:0] secs);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        kind             <= item_kind;
        acquired_seconds <= secs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Lets every pending result drain before touching the limit register.
    task automatic settle_and_write(input logic [LIMIT_W-1:0] value);
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly window items on a pool of nearby days, so hits, appends and a full table
    // all show up; the rest is restarts and fully random timestamps.
    task automatic run_phase(input int n_items, input int restart_pct);
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] key;
        logic [63:0]      secs;
        int               fresh;
        int               r;
        fresh = 0;
        if ($urandom_range(3) == 0)
            base = MAX_KEY - 24'd200;
        else
            base = KEY_W'($urandom_range(MAX_KEY - 200));
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(99);
            if (r < restart_pct)
                send_item(KIND_RESTART, random_seconds());
            else if (r < restart_pct + 12)
                send_item(KIND_WINDOW, random_seconds());
            else
            begin
                if (r < 55)
                begin
                    key = base + KEY_W'(fresh);
                    if (fresh < 200)
                        fresh++;
                end
                else
                    key = base + KEY_W'($urandom_range(fresh));
                secs = 64'(key) * 64'd86400 + 64'($urandom_range(86399));
                if (secs > 64'(MAX_SECS))
                    secs = 64'(MAX_SECS);
                send_item(KIND_WINDOW, secs[SECS_W-1:0]);
            end
        end
    endtask

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_limit[10];
        int                 phase_restart[10];
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = LIMIT_RESET;
        in_valid         = 1'b0;
        kind             = KIND_WINDOW;
        acquired_seconds = '0;
        calm             = 1'b0;
        hold_req         = 1'b0;
        phase_limit   = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd5, 7'd100, 7'd64, 7'd33, 7'd2, 7'd2};
        phase_restart = '{2, 1, 10, 10, 5, 1, 2, 3, 4, 8};
        phase_limit[8] = LIMIT_W'($urandom_range(63, 2));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset limit: lowest and highest timestamps, day boundaries, hits and a restart.
        send_item(KIND_WINDOW, '0);
        send_item(KIND_WINDOW, MAX_SECS);
        send_item(KIND_WINDOW, 40'd86399);
        send_item(KIND_WINDOW, 40'd86400);
        send_item(KIND_WINDOW, MAX_SECS - 1'b1);
        send_item(KIND_RESTART, MAX_SECS);
        send_item(KIND_WINDOW, 40'd86400 * 5);

        // Limit of one: a miss stops grouping; after a restart so does the first append.
        settle_and_write(7'd1);
        send_item(KIND_WINDOW, 40'd86400 * 7);
        send_item(KIND_WINDOW, 40'd86400 * 7 + 5);
        send_item(KIND_RESTART, '0);
        send_item(KIND_WINDOW, 40'd3);
        send_item(KIND_WINDOW, 40'd86400 * 9);

        // A zero limit behaves as a limit of one.
        settle_and_write(7'd0);
        send_item(KIND_RESTART, 40'd86400);
        send_item(KIND_WINDOW, 40'd86400 * 2);
        send_item(KIND_WINDOW, 40'd86400 * 3);

        // Lowering the limit below the used count: hits still count, a miss stops grouping.
        settle_and_write(7'd64);
        send_item(KIND_RESTART, '0);
        for (int k = 10; k < 15; k++)
            send_item(KIND_WINDOW, 40'(k) * 40'd86400 + 40'd123);
        settle_and_write(7'd3);
        send_item(KIND_WINDOW, 40'd11 * 40'd86400);
        send_item(KIND_WINDOW, 40'd20 * 40'd86400);
        send_item(KIND_WINDOW, 40'd11 * 40'd86400);
        send_item(KIND_RESTART, random_seconds());

        for (int p = 0; p < 10; p++)
        begin
            settle_and_write(phase_limit[p]);
            if (p == 1)
                hold_req <= 1'b1;
            calm <= (p == 6);
            @(negedge clk);
            run_phase(160, phase_restart[p]);
        end

        in_valid <= 1'b0;
        calm     <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
design/dbdc_pkg.sv
design/dbdc_ram.sv
design/dbdc_front.sv
design/dbdc_queue.sv
design/dbdc_back.sv
design/day_bucket_distinct_counter.sv
tb/day_bucket_distinct_checker.sv
tb/day_bucket_distinct_counter_tb.sv
